>>> design/resd_pkg.sv
// ----------------------------------------------------------------------------
// resd_pkg
// Shared types, widths, key codes and sequencer states for the record
// exchange sort core.
// ----------------------------------------------------------------------------
package resd_pkg;

    localparam int MAX_RECORDS_DEF = 64;

    localparam int ID_W     = 16;
    localparam int AGE_W    = 7;
    localparam int CRED_W   = 8;
    localparam int SALARY_W = 24;
    localparam int KEY_SEL_W = 2;

    localparam logic [KEY_SEL_W-1:0] KEY_CREDIBILITY    = 2'd0;
    localparam logic [KEY_SEL_W-1:0] KEY_CURRENT_SALARY = 2'd1;

    typedef struct packed {
        logic [ID_W-1:0]        id;
        logic [AGE_W-1:0]       age;
        logic signed [CRED_W-1:0] cred;
        logic [SALARY_W-1:0]    cur_salary;
        logic [SALARY_W-1:0]    old_salary;
    } record_t;

    typedef enum logic [6:0] {
        ST_LOAD    = 7'b0000001,
        ST_FETCH_I = 7'b0000010,
        ST_GET_I   = 7'b0000100,
        ST_CMP     = 7'b0001000,
        ST_WR_I    = 7'b0010000,
        ST_FETCH_O = 7'b0100000,
        ST_SHOW    = 7'b1000000
    } state_t;

    // Order-preserving unsigned key; credibility gets its sign bit flipped.
    function automatic logic [SALARY_W-1:0] key_of(input record_t rec,
                                                   input logic [KEY_SEL_W-1:0] sel);
        logic [SALARY_W-1:0] key;
        case (sel)
            KEY_CREDIBILITY: begin
                key = {{(SALARY_W-CRED_W){1'b0}}, ~rec.cred[CRED_W-1],
                       rec.cred[CRED_W-2:0]};
            end
            KEY_CURRENT_SALARY: begin
                key = rec.cur_salary;
            end
            default: begin
                key = rec.old_salary;
            end
        endcase
        return key;
    endfunction

endpackage

>>> design/record_exchange_sort_descending_core.sv
// Records load at one transaction per cycle; the last record starts the sort
// (playback if under two are held) on the single compare unit and a store
// with one write and one read port; then fetch, one result per m_ready cycle.
// Input is not ready from the last record until the final result is taken.
// Reset (aresetn, synchronous, active low) empties the set, clears the
// overflow flag and selects credibility as key; store contents are not reset.
// ----------------------------------------------------------------------------
// record_exchange_sort_descending_core
// Record store with an exchange sort in descending key order and playback.
// ----------------------------------------------------------------------------
module record_exchange_sort_descending_core #(
    parameter int MAX_RECORDS = resd_pkg::MAX_RECORDS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [resd_pkg::KEY_SEL_W-1:0]       cfg_data,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [resd_pkg::ID_W-1:0]            s_record_id,
    input  logic [resd_pkg::AGE_W-1:0]           s_age,
    input  logic signed [resd_pkg::CRED_W-1:0]   s_credibility,
    input  logic [resd_pkg::SALARY_W-1:0]        s_current_salary,
    input  logic [resd_pkg::SALARY_W-1:0]        s_former_salary,
    input  logic                                 s_last_in,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [resd_pkg::ID_W-1:0]            m_out_record_id,
    output logic [resd_pkg::AGE_W-1:0]           m_out_age,
    output logic signed [resd_pkg::CRED_W-1:0]   m_out_credibility,
    output logic [resd_pkg::SALARY_W-1:0]        m_out_current_salary,
    output logic [resd_pkg::SALARY_W-1:0]        m_out_former_salary,
    output logic                                 m_last_out,
    output logic                                 m_overflow
);
    import resd_pkg::*;

    localparam int ADDR_W = $clog2(MAX_RECORDS);
    localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RECORDS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    record_t store_mem [MAX_RECORDS];
    record_t rd_data_reg;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   dropped_reg, dropped_next;
    logic [KEY_SEL_W-1:0]   key_sel_reg;
    logic [ADDR_W-1:0]      i_reg, i_next;
    logic [ADDR_W-1:0]      j_reg, j_next;
    record_t                cur_reg, cur_next;

    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    record_t                wr_data;
    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;

    record_t                in_rec;
    logic                   in_fire;
    logic                   out_fire;
    logic                   has_room;
    logic [CNT_W-1:0]       n_after;
    logic [CNT_W-1:0]       i_plus1;
    logic [CNT_W-1:0]       j_plus1;
    logic                   swap;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_LOAD);
    assign m_valid   = (state_reg == ST_SHOW);
    assign in_fire   = s_valid && s_ready;
    assign out_fire  = m_valid && m_ready;

    assign in_rec.id         = s_record_id;
    assign in_rec.age        = s_age;
    assign in_rec.cred       = s_credibility;
    assign in_rec.cur_salary = s_current_salary;
    assign in_rec.old_salary = s_former_salary;

    assign has_room = (count_reg < CNT_MAX);
    assign n_after  = has_room ? (count_reg + CNT_ONE) : count_reg;
    assign i_plus1  = CNT_W'(i_reg) + CNT_ONE;
    assign j_plus1  = CNT_W'(j_reg) + CNT_ONE;
    assign swap     = (key_of(cur_reg, key_sel_reg) < key_of(rd_data_reg, key_sel_reg));

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        cur_next     = cur_reg;
        wr_en        = 1'b0;
        wr_addr      = count_reg[ADDR_W-1:0];
        wr_data      = in_rec;
        rd_en        = 1'b0;
        rd_addr      = i_reg;

        unique case (state_reg)
            ST_LOAD: begin
                if (in_fire) begin
                    if (has_room) begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_ONE;
                    end else begin
                        dropped_next = 1'b1;
                    end
                    if (s_last_in) begin
                        i_next     = '0;
                        state_next = (n_after > CNT_ONE) ? ST_FETCH_I : ST_FETCH_O;
                    end
                end
            end
            ST_FETCH_I: begin
                rd_en      = 1'b1;
                rd_addr    = i_reg;
                state_next = ST_GET_I;
            end
            ST_GET_I: begin
                cur_next   = rd_data_reg;
                j_next     = i_plus1[ADDR_W-1:0];
                rd_en      = 1'b1;
                rd_addr    = i_plus1[ADDR_W-1:0];
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (swap) begin
                    wr_en    = 1'b1;
                    wr_addr  = j_reg;
                    wr_data  = cur_reg;
                    cur_next = rd_data_reg;
                end
                if (j_plus1 < count_reg) begin
                    j_next  = j_plus1[ADDR_W-1:0];
                    rd_en   = 1'b1;
                    rd_addr = j_plus1[ADDR_W-1:0];
                end else begin
                    state_next = ST_WR_I;
                end
            end
            ST_WR_I: begin
                wr_en   = 1'b1;
                wr_addr = i_reg;
                wr_data = cur_reg;
                if ((i_plus1 + CNT_ONE) < count_reg) begin
                    i_next     = i_plus1[ADDR_W-1:0];
                    rd_en      = 1'b1;
                    rd_addr    = i_plus1[ADDR_W-1:0];
                    state_next = ST_GET_I;
                end else begin
                    i_next     = '0;
                    state_next = ST_FETCH_O;
                end
            end
            ST_FETCH_O: begin
                rd_en      = 1'b1;
                rd_addr    = i_reg;
                state_next = ST_SHOW;
            end
            ST_SHOW: begin
                if (out_fire) begin
                    if (i_plus1 == count_reg) begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                        state_next   = ST_LOAD;
                    end else begin
                        i_next  = i_plus1[ADDR_W-1:0];
                        rd_en   = 1'b1;
                        rd_addr = i_plus1[ADDR_W-1:0];
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            key_sel_reg <= KEY_CREDIBILITY;
            i_reg       <= '0;
            j_reg       <= '0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            if (cfg_valid && cfg_ready) begin
                key_sel_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign m_out_record_id      = rd_data_reg.id;
    assign m_out_age            = rd_data_reg.age;
    assign m_out_credibility    = rd_data_reg.cred;
    assign m_out_current_salary = rd_data_reg.cur_salary;
    assign m_out_former_salary  = rd_data_reg.old_salary;
    assign m_last_out           = (i_plus1 == count_reg);
    assign m_overflow           = dropped_reg;

endmodule
